>>> src/bfea_pkg.sv
// Shared types and codes for the best-fit extent allocator.
package bfea_pkg;

  localparam int unsigned SizeW = 21;
  localparam int unsigned OffW  = 20;

  // arena size and allocation granule (power of two) in bytes
  localparam int unsigned ArenaBytes = 1048576;
  localparam int unsigned Granule    = 8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_SWAIT = 9'b000000100,
    S_DEC   = 9'b000001000,
    S_SHIFT = 9'b000010000,
    S_SHW   = 9'b000100000,
    S_PATCH = 9'b001000000,
    S_PWAIT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

endpackage

>>> src/best_fit_extent_allocator_core.sv
// Best-fit extent allocator: sorted free-extent table in one memory, scanned per request.
//
//  channel  | ports                                        | handshake
//  request  | operation_i block_size_i block_offset_i      | start while busy low
//  result   | status_o granted_offset_o bytes_in_use_o     | done_o, one cycle, no stall
//           | peak_bytes_o                                 |
//
// A request runs from acceptance to the done_o cycle as: a read, then a compare, for each
// extent scanned; a decision; a read, hold and write for each entry moved while the table
// is shifted to open or close a slot; then the slot write and the done cycle. Worst case
// is a free inserted at the table's head.
// Reset leaves one free extent covering the arena; no clearing pass is needed.
// busy stays high from acceptance through the done_o cycle; results are never held off.
module best_fit_extent_allocator_core #(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation_i,
  input  logic [bfea_pkg::SizeW-1:0] block_size_i,
  input  logic [bfea_pkg::OffW-1:0]  block_offset_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [bfea_pkg::OffW-1:0]  granted_offset_o,
  output logic [bfea_pkg::SizeW-1:0] bytes_in_use_o,
  output logic [bfea_pkg::SizeW-1:0] peak_bytes_o
);
  import bfea_pkg::*;

  localparam int unsigned AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned VW = $clog2(ArenaBytes + 1) + 1;
  localparam int unsigned EW = 2 * VW;
  localparam int unsigned GW = (Granule > 1) ? $clog2(Granule) : 1;
  localparam logic [VW-1:0] ArenaV = VW'(ArenaBytes);
  localparam logic [CW-1:0] MaxC   = CW'(MAX_EXTENTS);

  // extent memory: {start, length}
  logic [EW-1:0] mem_q [MAX_EXTENTS];
  logic [EW-1:0] rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  state_e        state_q, state_d;
  logic          init_q, init_d;   // entry 0 not yet written since reset
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] use_q, use_d, peak_q, peak_d;
  logic          op_q, op_d;
  logic [VW-1:0] req_q, req_d, sz_q, sz_d, off_q, off_d;
  logic [CW-1:0] idx_q, idx_d;     // scan index / shift index
  logic          have_q, have_d, exact_q, exact_d, found_q, found_d;
  logic [AW-1:0] best_q, best_d;
  logic [VW-1:0] bst_q, bst_d, blen_q, blen_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [VW-1:0] ps_q, ps_d, pl_q, pl_d, ns_q, ns_d, nl_q, nl_d;
  logic [1:0]    st_q, st_d;
  logic [OffW-1:0] gr_q, gr_d;
  logic          dir_q, dir_d;     // shift: 1 open slot (move up), 0 close slot
  logic [CW-1:0] lim_q, lim_d;
  logic          done_q, done_d;

  logic [VW-1:0] rs, rl;
  assign rs = init_q ? ((idx_q == '0) ? '0 : rdata_q[EW-1:VW]) : rdata_q[EW-1:VW];
  assign rl = init_q ? ((idx_q == '0) ? ArenaV : rdata_q[VW-1:0]) : rdata_q[VW-1:0];

  logic [VW-1:0] rsz;
  assign rsz = ((VW'(block_size_i) + VW'(Granule - 1)) >> GW) << GW;

  always_comb begin
    state_d = state_q; init_d = init_q; cnt_d = cnt_q; use_d = use_q; peak_d = peak_q;
    op_d = op_q; req_d = req_q; sz_d = sz_q; off_d = off_q; idx_d = idx_q;
    have_d = have_q; exact_d = exact_q; found_d = found_q; best_d = best_q;
    bst_d = bst_q; blen_d = blen_q; pos_d = pos_q; ps_d = ps_q; pl_d = pl_q;
    ns_d = ns_q; nl_d = nl_q; st_d = st_q; gr_d = gr_q; dir_d = dir_q; lim_d = lim_q;
    done_d = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0; raddr = idx_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (start && !busy) begin
          op_d = operation_i; req_d = VW'(block_size_i); off_d = VW'(block_offset_i);
          sz_d = (Granule == 1) ? VW'(block_size_i) : rsz;
          idx_d = '0; have_d = 1'b0; exact_d = 1'b0; found_d = 1'b0;
          pos_d = cnt_q; gr_d = '0; ps_d = '0; pl_d = '0;
          raddr = '0;
          // empty table: nothing to scan
          state_d = (cnt_q == '0) ? S_DEC : S_SWAIT;
        end
      end
      S_SWAIT: state_d = S_SCAN;
      S_SCAN: begin
        // rdata holds entry idx_q
        if (op_q == OP_ALLOC) begin
          if (rl == sz_q) begin
            exact_d = 1'b1; have_d = 1'b1; best_d = idx_q[AW-1:0];
            bst_d = rs; blen_d = rl; state_d = S_DEC;
          end else if (rl > sz_q && (!have_q || rl < blen_q)) begin
            have_d = 1'b1; best_d = idx_q[AW-1:0]; bst_d = rs; blen_d = rl;
          end
        end else begin
          if (rs <= off_q) begin
            ps_d = rs; pl_d = rl;
          end else begin
            pos_d = idx_q; ns_d = rs; nl_d = rl; found_d = 1'b1; state_d = S_DEC;
          end
        end
        if (state_d == S_SCAN) begin
          if (idx_q + 1'b1 >= cnt_q) begin
            state_d = S_DEC;
            if (op_q == OP_FREE) pos_d = cnt_q;
          end else begin
            idx_d = idx_q + 1'b1; raddr = AW'(idx_q + 1'b1); state_d = S_SWAIT;
          end
        end
      end
      S_DEC: begin
        state_d = S_DONE;
        if (op_q == OP_ALLOC) begin
          if (sz_q == '0 || sz_q > ArenaV || !have_q) st_d = ST_NOSPACE;
          else begin
            st_d = ST_OK;
            use_d = (req_q > ArenaV - use_q) ? ArenaV : use_q + req_q;
            if (use_d > peak_q) peak_d = use_d;
            if (exact_q) begin
              gr_d = OffW'(bst_q);
              if (init_q && best_q == '0) init_d = 1'b0;
              dir_d = 1'b0; idx_d = CW'(best_q); lim_d = cnt_q; cnt_d = cnt_q - 1'b1;
              state_d = S_SHIFT;
            end else begin
              gr_d = OffW'(bst_q + blen_q - sz_q);
              we = 1'b1; waddr = best_q; wdata = {bst_q, blen_q - sz_q};
              if (best_q == '0) init_d = 1'b0;
            end
          end
        end else begin
          logic jp, jn;
          jp = (pos_q != '0) && (ps_q + pl_q == off_q);
          jn = found_q && (ns_q == off_q + sz_q);
          if (sz_q == '0 || sz_q > ArenaV || off_q > ArenaV - sz_q) st_d = ST_BADFREE;
          else if (pos_q != '0 && ps_q + pl_q > off_q) st_d = ST_BADFREE;
          else if (found_q && ns_q < off_q + sz_q) st_d = ST_BADFREE;
          else if (!jp && !jn && cnt_q >= MaxC) st_d = ST_FULL;
          else begin
            st_d = ST_OK;
            use_d = (req_q >= use_q) ? '0 : use_q - req_q;
            if (jp && jn) begin
              we = 1'b1; waddr = AW'(pos_q - 1'b1); wdata = {ps_q, pl_q + sz_q + nl_q};
              if (pos_q == CW'(1)) init_d = 1'b0;
              dir_d = 1'b0; idx_d = pos_q; lim_d = cnt_q; cnt_d = cnt_q - 1'b1;
              state_d = S_SHIFT;
            end else if (jp) begin
              we = 1'b1; waddr = AW'(pos_q - 1'b1); wdata = {ps_q, pl_q + sz_q};
              if (pos_q == CW'(1)) init_d = 1'b0;
            end else if (jn) begin
              we = 1'b1; waddr = AW'(pos_q); wdata = {off_q, nl_q + sz_q};
              if (pos_q == '0) init_d = 1'b0;
            end else begin
              dir_d = 1'b1; idx_d = cnt_q; lim_d = pos_q; cnt_d = cnt_q + 1'b1;
              state_d = S_SHIFT;
            end
          end
        end
      end
      S_SHIFT: begin
        // read the source entry of the next move
        if (dir_q) begin
          if (idx_q <= lim_q) state_d = S_PATCH;
          else begin raddr = AW'(idx_q - 1'b1); state_d = S_SHW; end
        end else begin
          if (idx_q + 1'b1 >= lim_q) state_d = S_DONE;
          else begin raddr = AW'(idx_q + 1'b1); state_d = S_SHW; end
        end
      end
      S_SHW: begin
        // keep the source address so rdata still holds it next cycle
        raddr = dir_q ? AW'(idx_q - 1'b1) : AW'(idx_q + 1'b1);
        state_d = S_PWAIT;
      end
      S_PWAIT: begin
        we = 1'b1; waddr = idx_q[AW-1:0];
        // source index zero only when moving up from entry 0
        wdata = (init_q && dir_q && idx_q == CW'(1)) ? {VW'(0), ArenaV} : rdata_q;
        if (dir_q) begin
          if (idx_q == CW'(1)) init_d = 1'b0;
          idx_d = idx_q - 1'b1;
        end else idx_d = idx_q + 1'b1;
        state_d = S_SHIFT;
      end
      S_PATCH: begin
        we = 1'b1; waddr = pos_q[AW-1:0]; wdata = {off_q, sz_q};
        if (pos_q == '0) init_d = 1'b0;
        state_d = S_DONE;
      end
      S_DONE: begin
        done_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; init_q <= 1'b1; cnt_q <= CW'(1);
      use_q <= '0; peak_q <= '0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; init_q <= init_d; cnt_q <= cnt_d;
      use_q <= use_d; peak_q <= peak_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; req_q <= req_d; sz_q <= sz_d; off_q <= off_d; idx_q <= idx_d;
    have_q <= have_d; exact_q <= exact_d; found_q <= found_d; best_q <= best_d;
    bst_q <= bst_d; blen_q <= blen_d; pos_q <= pos_d; ps_q <= ps_d; pl_q <= pl_d;
    ns_q <= ns_d; nl_q <= nl_d; st_q <= st_d; gr_q <= gr_d; dir_q <= dir_d;
    lim_q <= lim_d;
  end

  assign busy             = (state_q != S_IDLE) || done_q;
  assign done_o           = done_q;
  assign status_o         = st_q;
  assign granted_offset_o = gr_q;
  assign bytes_in_use_o   = SizeW'(use_q);
  assign peak_bytes_o     = SizeW'(peak_q);

endmodule

>>> sim/best_fit_extent_allocator_core_test.sv
// Testbench for the best-fit extent allocator: directed table plus random alloc/free traffic.
`timescale 1ns / 100ps

module best_fit_extent_allocator_core_test;
  import bfea_pkg::*;

  localparam int unsigned Arena   = 1048576;
  localparam int unsigned MaxExt  = 64;
  localparam int unsigned Gran    = 8;
  localparam int unsigned WdLimit = 20000;
  localparam int unsigned NumRand = 700;

  typedef struct packed {
    status_e            status;
    logic [OffW-1:0]    granted;
    logic [SizeW-1:0]   in_use;
    logic [SizeW-1:0]   peak;
  } word_t;

  typedef struct packed {
    op_e                op;
    logic [SizeW-1:0]   size;
    logic [OffW-1:0]    offset;
    logic               typed;
    status_e            status;
    logic [OffW-1:0]    granted;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             operation_i = 1'b0;
  logic [SizeW-1:0] block_size_i = '0;
  logic [OffW-1:0]  block_offset_i = '0;
  logic             done_o;
  logic [1:0]       status_o;
  logic [OffW-1:0]  granted_offset_o;
  logic [SizeW-1:0] bytes_in_use_o;
  logic [SizeW-1:0] peak_bytes_o;

  best_fit_extent_allocator_core dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .block_size_i, .block_offset_i,
    .done_o, .status_o, .granted_offset_o, .bytes_in_use_o, .peak_bytes_o
  );

  always #1 clk_i = ~clk_i;

  // free-extent table as the allocator should hold it
  int unsigned ext_base [MaxExt];
  int unsigned ext_len  [MaxExt];
  int unsigned ext_cnt = 1;
  int unsigned used_bytes = 0;
  int unsigned peak_used = 0;

  word_t       pending_words[$];
  int unsigned live_off[$];
  int unsigned live_size[$];
  int unsigned n_fail = 0;
  int unsigned n_alloc_ok = 0, n_free_ok = 0, n_nospace = 0, n_badfree = 0, n_full = 0;
  int unsigned idle_cycles = 0;

  function automatic int unsigned round_gran(int unsigned n);
    return ((n + Gran - 1) / Gran) * Gran;
  endfunction

  function automatic void drop_extent(int unsigned i);
    for (int unsigned k = i; k + 1 < ext_cnt; k++) begin
      ext_base[k] = ext_base[k+1];
      ext_len[k]  = ext_len[k+1];
    end
    ext_cnt--;
  endfunction

  function automatic status_e carve_block(int unsigned req, output int unsigned got);
    int unsigned sz;
    int unsigned best;
    int unsigned best_len;
    bit          have;
    sz = round_gran(req);
    best = 0;
    best_len = 0;
    have = 1'b0;
    got = 0;
    if (sz == 0 || sz > Arena) return ST_NOSPACE;
    for (int unsigned i = 0; i < ext_cnt; i++) begin
      if (ext_len[i] == sz) begin
        got = ext_base[i];
        drop_extent(i);
        return ST_OK;
      end
      if (ext_len[i] > sz && (!have || ext_len[i] < best_len)) begin
        have = 1'b1;
        best = i;
        best_len = ext_len[i];
      end
    end
    if (!have) return ST_NOSPACE;
    ext_len[best] -= sz;
    got = ext_base[best] + ext_len[best];
    return ST_OK;
  endfunction

  function automatic status_e return_block(int unsigned req, int unsigned off);
    int unsigned sz, last, pos, pend;
    bit          jp, jn;
    sz = round_gran(req);
    jp = 1'b0;
    jn = 1'b0;
    if (sz == 0 || sz > Arena || off > Arena - sz) return ST_BADFREE;
    last = off + sz;
    pos = 0;
    while (pos < ext_cnt && ext_base[pos] <= off) pos++;
    if (pos > 0) begin
      pend = ext_base[pos-1] + ext_len[pos-1];
      if (pend > off) return ST_BADFREE;
      jp = (pend == off);
    end
    if (pos < ext_cnt) begin
      if (ext_base[pos] < last) return ST_BADFREE;
      jn = (ext_base[pos] == last);
    end
    if (jp && jn) begin
      ext_len[pos-1] += sz + ext_len[pos];
      drop_extent(pos);
    end else if (jp) begin
      ext_len[pos-1] += sz;
    end else if (jn) begin
      ext_base[pos] = off;
      ext_len[pos] += sz;
    end else begin
      if (ext_cnt >= MaxExt) return ST_FULL;
      for (int unsigned k = ext_cnt; k > pos; k--) begin
        ext_base[k] = ext_base[k-1];
        ext_len[k]  = ext_len[k-1];
      end
      ext_base[pos] = off;
      ext_len[pos]  = sz;
      ext_cnt++;
    end
    return ST_OK;
  endfunction

  // advances the allocator state by one request and returns the word it should produce
  function automatic word_t allocator_step(op_e op, int unsigned size, int unsigned off);
    word_t       w;
    int unsigned got;
    got = 0;
    if (op == OP_ALLOC) begin
      w.status = carve_block(size, got);
      if (w.status == ST_OK) begin
        used_bytes = (size > Arena - used_bytes) ? Arena : used_bytes + size;
        if (used_bytes > peak_used) peak_used = used_bytes;
        live_off.push_back(got);
        live_size.push_back(size);
        n_alloc_ok++;
      end
    end else begin
      w.status = return_block(size, off);
      if (w.status == ST_OK) begin
        used_bytes = (size >= used_bytes) ? 0 : used_bytes - size;
        n_free_ok++;
      end
    end
    case (w.status)
      ST_NOSPACE: n_nospace++;
      ST_BADFREE: n_badfree++;
      ST_FULL:    n_full++;
      default: ;
    endcase
    w.granted = got[OffW-1:0];
    w.in_use  = used_bytes[SizeW-1:0];
    w.peak    = peak_used[SizeW-1:0];
    return w;
  endfunction

  // drives one request and waits for it to be taken
  task automatic send_request(op_e op, logic [SizeW-1:0] size, logic [OffW-1:0] off,
                              bit typed = 1'b0, status_e t_status = ST_OK,
                              logic [OffW-1:0] t_granted = '0);
    word_t w;
    @(negedge clk_i);
    operation_i    <= op;
    block_size_i   <= size;
    block_offset_i <= off;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    w = allocator_step(op, 32'(size), 32'(off));
    if (typed) begin
      w.status  = t_status;
      w.granted = t_granted;
    end
    pending_words.push_back(w);
  endtask

  task automatic hold_off(int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic free_live(int unsigned idx);
    int unsigned off, sz;
    off = live_off[idx];
    sz  = live_size[idx];
    live_off.delete(idx);
    live_size.delete(idx);
    // any byte count with the same rounding frees the same block
    if ($urandom_range(0, 3) == 0) sz = round_gran(sz) - $urandom_range(0, Gran - 1);
    if (sz == 0) sz = 1;
    send_request(OP_FREE, SizeW'(sz), OffW'(off));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        n_fail++;
      end else begin
        word_t w;
        w = pending_words.pop_front();
        if (status_o !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, status_o);
          n_fail++;
        end
        if (granted_offset_o !== w.granted) begin
          $error("granted_offset: expected %0d, got %0d", w.granted, granted_offset_o);
          n_fail++;
        end
        if (bytes_in_use_o !== w.in_use) begin
          $error("bytes_in_use: expected %0d, got %0d", w.in_use, bytes_in_use_o);
          n_fail++;
        end
        if (peak_bytes_o !== w.peak) begin
          $error("peak_bytes: expected %0d, got %0d", w.peak, peak_bytes_o);
          n_fail++;
        end
      end
    end
  end

  // watchdog: cycles with no request taken and no word out
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WdLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  row_t dir_rows [21] = '{
    '{OP_ALLOC, 21'd0,       20'd0,       1'b1, ST_NOSPACE, 20'd0},
    '{OP_ALLOC, 21'h1FFFFF,  20'hFFFFF,   1'b1, ST_NOSPACE, 20'd0},
    '{OP_ALLOC, 21'd1048577, 20'd0,       1'b1, ST_NOSPACE, 20'd0},
    '{OP_FREE,  21'd0,       20'd0,       1'b1, ST_BADFREE, 20'd0},
    '{OP_FREE,  21'h1FFFFF,  20'd0,       1'b1, ST_BADFREE, 20'd0},
    '{OP_ALLOC, 21'd1048576, 20'd0,       1'b1, ST_OK,      20'd0},
    '{OP_ALLOC, 21'd8,       20'd0,       1'b1, ST_NOSPACE, 20'd0},
    '{OP_FREE,  21'd8,       20'hFFFFF,   1'b1, ST_BADFREE, 20'd0},
    '{OP_FREE,  21'd1048576, 20'd0,       1'b1, ST_OK,      20'd0},
    '{OP_ALLOC, 21'd1,       20'd0,       1'b1, ST_OK,      20'd1048568},
    '{OP_FREE,  21'd8,       20'd0,       1'b1, ST_BADFREE, 20'd0},
    '{OP_ALLOC, 21'd100,     20'hFFFFF,   1'b0, ST_OK,      20'd0},
    '{OP_ALLOC, 21'd24,      20'd0,       1'b0, ST_OK,      20'd0},
    '{OP_FREE,  21'd104,     20'd1048440, 1'b0, ST_OK,      20'd0},
    '{OP_ALLOC, 21'd104,     20'd0,       1'b0, ST_OK,      20'd0},
    '{OP_FREE,  21'd16,      20'd1048536, 1'b0, ST_OK,      20'd0},
    '{OP_FREE,  21'd8,       20'd1048432, 1'b0, ST_OK,      20'd0},
    '{OP_FREE,  21'd104,     20'd1048440, 1'b0, ST_OK,      20'd0},
    '{OP_FREE,  21'd8,       20'd1048568, 1'b0, ST_OK,      20'd0},
    '{OP_FREE,  21'd8,       20'd1048560, 1'b0, ST_OK,      20'd0},
    '{OP_FREE,  21'd8,       20'd1048544, 1'b0, ST_OK,      20'd0}
  };

  initial begin
    int unsigned nsent, burst, pick;
    for (int i = 0; i < MaxExt; i++) begin
      ext_base[i] = 0;
      ext_len[i]  = 0;
    end
    ext_len[0] = Arena;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].size, dir_rows[i].offset,
                   dir_rows[i].typed, dir_rows[i].status, dir_rows[i].granted);
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(0, 5));
    end
    // blocks left from the directed rows stay allocated; only later ones get freed
    hold_off(0);
    wait (pending_words.size() == 0);
    live_off.delete();
    live_size.delete();

    // fragment the arena until the extent table fills up
    for (int i = 0; i < 140; i++) send_request(OP_ALLOC, 21'($urandom_range(1, 8)), '0);
    for (int i = 139; i >= 0; i -= 2) free_live(i);
    hold_off(3);
    wait (pending_words.size() == 0);
    hold_off(2);

    nsent = 0;
    while (nsent < NumRand) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && nsent < NumRand; b++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          if ($urandom_range(0, 15) == 0)
            send_request(OP_ALLOC, 21'($urandom_range(1, Arena)), 20'($urandom));
          else
            send_request(OP_ALLOC, 21'($urandom_range(1, 4096)), 20'($urandom));
        end else if (pick < 88 && live_off.size() > 0) begin
          free_live($urandom_range(0, live_off.size() - 1));
        end else if (pick < 94) begin
          send_request(op_e'($urandom_range(0, 1)), 21'($urandom), 20'($urandom));
        end else begin
          send_request(OP_FREE, 21'($urandom_range(0, 64)), 20'($urandom_range(0, Arena - 1)));
        end
        nsent++;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(0, 12));
    end
    hold_off(0);
    wait (pending_words.size() == 0);
    repeat (2 * MaxExt + 16) @(posedge clk_i);

    $display("run: %0d allocs and %0d frees granted, %0d no-space, %0d bad frees, %0d table-full",
             n_alloc_ok, n_free_ok, n_nospace, n_badfree, n_full);
    $display("run: peak %0d bytes in use, %0d extents at end", peak_used, ext_cnt);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
src/bfea_pkg.sv
src/best_fit_extent_allocator_core.sv
sim/best_fit_extent_allocator_core_test.sv
